// File: rtl/core/cramt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the circular range add and minimum tree.
// No dependencies; the core and the divider refer to this package by scoped names.
package cramt_pkg;

	localparam int LEAF_BITS    = 10;
	localparam int NODE_BITS    = LEAF_BITS + 1;
	localparam int LEVEL_BITS   = 4;
	localparam int MAX_ELEMENTS = 1 << LEAF_BITS;
	localparam int NODE_COUNT   = 2 * MAX_ELEMENTS;
	localparam int LAST_LEVEL   = LEAF_BITS - 1;
	localparam int VALUE_WIDTH  = 48;
	localparam int SIZE_WIDTH   = 11;
	localparam int COORD_WIDTH  = 12;
	localparam int CMD_WIDTH    = 2;
	localparam int DIV_STEPS    = COORD_WIDTH;
	localparam int STEP_BITS    = 4;

	localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = SIZE_WIDTH'(MAX_ELEMENTS);

	typedef enum logic [CMD_WIDTH-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRAP,
		ST_PASS,
		ST_ROOT_RD,
		ST_ROOT_DO,
		ST_D_SEL,
		ST_D_PAR,
		ST_D_CRD,
		ST_D_CWR,
		ST_D_CAP,
		ST_LEAF,
		ST_U_SEL,
		ST_U_RD1,
		ST_U_WR,
		ST_PASS_END,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] pend;
		logic [LEAF_BITS-1:0]          arg;
		logic signed [VALUE_WIDTH-1:0] mn;
	} node_t;

	typedef struct packed {
		logic                 done;
		logic [LEAF_BITS-1:0] left_pos;
		logic [LEAF_BITS-1:0] right_pos;
	} div_res_t;

	function automatic logic signed [VALUE_WIDTH-1:0] sat_add(
		logic signed [VALUE_WIDTH-1:0] a,
		logic signed [VALUE_WIDTH-1:0] b
	);
		logic signed [VALUE_WIDTH:0] s;
		s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
		if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
			return s[VALUE_WIDTH] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
			                      : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
		end
		return s[VALUE_WIDTH-1:0];
	endfunction

	function automatic node_t apply_add(node_t n, logic signed [VALUE_WIDTH-1:0] a);
		node_t r;
		r      = n;
		r.mn   = sat_add(n.mn, a);
		r.pend = sat_add(n.pend, a);
		return r;
	endfunction

	function automatic logic [NODE_BITS-1:0] path_node(
		logic [LEAF_BITS-1:0]  pos,
		logic [LEVEL_BITS-1:0] lvl
	);
		logic [NODE_BITS-1:0] leaf;
		leaf = {1'b1, pos};
		return leaf >> (LEVEL_BITS'(LEAF_BITS) - lvl);
	endfunction

	function automatic logic [LEAF_BITS-1:0] first_leaf(
		logic [NODE_BITS-1:0]  node,
		logic [LEVEL_BITS-1:0] lvl
	);
		logic [NODE_BITS-1:0] sh;
		sh = node << (LEVEL_BITS'(LEAF_BITS) - lvl);
		return sh[LEAF_BITS-1:0];
	endfunction

	function automatic logic [LEAF_BITS-1:0] span_mask(logic [LEVEL_BITS-1:0] lvl);
		logic [NODE_BITS-1:0] m;
		m = (NODE_BITS'(1) << (LEVEL_BITS'(LEAF_BITS) - lvl)) - NODE_BITS'(1);
		return m[LEAF_BITS-1:0];
	endfunction

	function automatic logic [LEAF_BITS-1:0] clear_arg(logic [NODE_BITS-1:0] node);
		logic [NODE_BITS-1:0] sh;
		logic                 hit;
		sh  = '0;
		hit = 1'b0;
		for (int i = 0; i < NODE_BITS; i++) begin
			if (!hit && node[NODE_BITS-1-i]) begin
				sh  = node << i;
				hit = 1'b1;
			end
		end
		return sh[LEAF_BITS-1:0];
	endfunction

endpackage

// File: rtl/core/circular_range_add_min_tree_core.sv
`timescale 1ns / 1ps
// Top level of the circular range add and minimum store: sequencer, node memory and adder.
// Depends on cramt_pkg, cramt_ram and cramt_div.
// Each request runs a bound reduction and then one pass over the tree paths, with further
// steps for each node visited on the way down and on the way up; a wrapping range takes
// two passes. Requests are taken one at a time. After reset a clearing pass initialises
// the tree, during which no request is taken.
module circular_range_add_min_tree_core (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_wr_en,
	input  logic [cramt_pkg::SIZE_WIDTH-1:0]         cfg_wr_data,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic [cramt_pkg::CMD_WIDTH-1:0]          command,
	input  logic signed [cramt_pkg::COORD_WIDTH-1:0] left,
	input  logic signed [cramt_pkg::COORD_WIDTH-1:0] right,
	input  logic signed [cramt_pkg::VALUE_WIDTH-1:0] value,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic signed [cramt_pkg::VALUE_WIDTH-1:0] min_value,
	output logic [cramt_pkg::LEAF_BITS-1:0]          min_index
);

	cramt_pkg::state_t state_q, state_d;

	logic [cramt_pkg::NODE_BITS-1:0]         clr_q;
	logic [cramt_pkg::SIZE_WIDTH-1:0]        size_q;
	logic [cramt_pkg::SIZE_WIDTH-1:0]        n_eff;
	logic [cramt_pkg::SIZE_WIDTH-1:0]        n_less;
	logic [cramt_pkg::CMD_WIDTH-1:0]         cmd_q;
	logic signed [cramt_pkg::VALUE_WIDTH-1:0] value_q;
	logic [cramt_pkg::LEAF_BITS-1:0]         pl_q, pr_q, bl_q, br_q;
	logic                                    second_q;
	logic [cramt_pkg::LEVEL_BITS-1:0]        lvl_q;
	logic                                    side_q;
	logic                                    ch_q;
	logic [cramt_pkg::NODE_BITS-1:0]         v_q;
	logic signed [cramt_pkg::VALUE_WIDTH-1:0] p_q;
	cramt_pkg::node_t                        cw_q;
	logic signed [cramt_pkg::VALUE_WIDTH-1:0] best_mn_q;
	logic [cramt_pkg::LEAF_BITS-1:0]         best_arg_q;
	logic [cramt_pkg::LEAF_BITS-1:0]         best_key_q;
	logic                                    found_q;
	logic                                    out_valid_q;
	logic signed [cramt_pkg::VALUE_WIDTH-1:0] min_value_q;
	logic [cramt_pkg::LEAF_BITS-1:0]         min_index_q;

	logic                                    accept, cmd_ok;
	logic                                    is_load, is_add, is_qry;
	logic [cramt_pkg::LEAF_BITS-1:0]         cur_pos, lo_w, hi_w, clo, chi;
	logic [cramt_pkg::NODE_BITS-1:0]         node_w, child_w;
	logic [cramt_pkg::LEVEL_BITS-1:0]        clv;
	logic                                    partial_w, dup_w, visit_w, ccov, cskip;
	logic                                    last_d, last_u, root_cov, out_free;
	cramt_pkg::state_t                       down_end;

	logic                                    ram_we, ram_re;
	logic [cramt_pkg::NODE_BITS-1:0]         ram_waddr, ram_raddr;
	cramt_pkg::node_t                        ram_wdata, ram_rdata;
	cramt_pkg::node_t                        alu_in, alu_out;
	logic signed [cramt_pkg::VALUE_WIDTH-1:0] alu_add;
	cramt_pkg::node_t                        cmp_node;
	logic [cramt_pkg::LEAF_BITS-1:0]         cmp_key;
	logic                                    cmp_en, cmp_take, pick_left;
	cramt_pkg::div_res_t                     div_res;

	cramt_ram #(
		.WIDTH($bits(cramt_pkg::node_t)),
		.DEPTH(cramt_pkg::NODE_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	cramt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && cmd_ok),
		.left   (left),
		.right  (right),
		.modulus(n_eff),
		.res    (div_res)
	);

	// A size of zero acts as one and anything beyond the tree acts as the full tree.
	always_comb begin
		if (size_q == '0) begin
			n_eff = cramt_pkg::SIZE_WIDTH'(1);
		end else if (size_q > cramt_pkg::SIZE_WIDTH'(cramt_pkg::MAX_ELEMENTS)) begin
			n_eff = cramt_pkg::SIZE_WIDTH'(cramt_pkg::MAX_ELEMENTS);
		end else begin
			n_eff = size_q;
		end
		n_less = n_eff - 1'b1;
	end

	assign in_stall = (state_q != cramt_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign cmd_ok   = (command == cramt_pkg::CMD_LOAD) || (command == cramt_pkg::CMD_ADD)
	               || (command == cramt_pkg::CMD_QUERY);
	assign is_load  = (cmd_q == cramt_pkg::CMD_LOAD);
	assign is_add   = (cmd_q == cramt_pkg::CMD_ADD);
	assign is_qry   = (cmd_q == cramt_pkg::CMD_QUERY);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cur_pos   = side_q ? pr_q : pl_q;
		node_w    = cramt_pkg::path_node(cur_pos, lvl_q);
		lo_w      = cramt_pkg::first_leaf(node_w, lvl_q);
		hi_w      = lo_w | cramt_pkg::span_mask(lvl_q);
		partial_w = !(hi_w < pl_q || lo_w > pr_q) && !(pl_q <= lo_w && hi_w <= pr_q);
		dup_w     = side_q && (cramt_pkg::path_node(pr_q, lvl_q)
		                       == cramt_pkg::path_node(pl_q, lvl_q));
		visit_w   = is_load ? !side_q : (partial_w && !dup_w);
		child_w   = {v_q[cramt_pkg::NODE_BITS-2:0], ch_q};
		clv       = lvl_q + 1'b1;
		clo       = cramt_pkg::first_leaf(child_w, clv);
		chi       = clo | cramt_pkg::span_mask(clv);
		ccov      = !is_load && pl_q <= clo && chi <= pr_q;
		cskip     = (p_q == '0) && !ccov;
		last_d    = (lvl_q == cramt_pkg::LEVEL_BITS'(cramt_pkg::LAST_LEVEL))
		            && (side_q || is_load);
		last_u    = (lvl_q == '0) && (side_q || is_load);
		root_cov  = !is_load && pl_q == '0 && pr_q == '1;
		if (is_load) begin
			down_end = cramt_pkg::ST_LEAF;
		end else if (is_add) begin
			down_end = cramt_pkg::ST_U_SEL;
		end else begin
			down_end = cramt_pkg::ST_PASS_END;
		end
	end

	always_comb begin
		alu_out = cramt_pkg::apply_add(alu_in, alu_add);
	end

	always_comb begin
		cmp_take  = !found_q || ($signed(cmp_node.mn) < $signed(best_mn_q))
		            || (cmp_node.mn == best_mn_q && cmp_key < best_key_q);
		pick_left = $signed(cw_q.mn) <= $signed(ram_rdata.mn);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			cramt_pkg::ST_CLEAR: begin
				if (clr_q == cramt_pkg::NODE_BITS'(cramt_pkg::NODE_COUNT - 1)) begin
					state_d = cramt_pkg::ST_IDLE;
				end
			end
			cramt_pkg::ST_IDLE: begin
				if (accept && cmd_ok) begin
					state_d = cramt_pkg::ST_WRAP;
				end
			end
			cramt_pkg::ST_WRAP: begin
				if (div_res.done) begin
					state_d = cramt_pkg::ST_PASS;
				end
			end
			cramt_pkg::ST_PASS: begin
				state_d = root_cov ? cramt_pkg::ST_ROOT_RD : cramt_pkg::ST_D_SEL;
			end
			cramt_pkg::ST_ROOT_RD: state_d = cramt_pkg::ST_ROOT_DO;
			cramt_pkg::ST_ROOT_DO: state_d = cramt_pkg::ST_PASS_END;
			cramt_pkg::ST_D_SEL: begin
				if (visit_w) begin
					state_d = cramt_pkg::ST_D_PAR;
				end else if (last_d) begin
					state_d = down_end;
				end
			end
			cramt_pkg::ST_D_PAR: state_d = cramt_pkg::ST_D_CRD;
			cramt_pkg::ST_D_CRD: begin
				if (!cskip) begin
					state_d = cramt_pkg::ST_D_CWR;
				end else if (ch_q) begin
					state_d = last_d ? down_end : cramt_pkg::ST_D_SEL;
				end
			end
			cramt_pkg::ST_D_CWR: state_d = cramt_pkg::ST_D_CAP;
			cramt_pkg::ST_D_CAP: begin
				if (ch_q) begin
					state_d = last_d ? down_end : cramt_pkg::ST_D_SEL;
				end else begin
					state_d = cramt_pkg::ST_D_CRD;
				end
			end
			cramt_pkg::ST_LEAF: state_d = cramt_pkg::ST_U_SEL;
			cramt_pkg::ST_U_SEL: begin
				if (visit_w) begin
					state_d = cramt_pkg::ST_U_RD1;
				end else if (last_u) begin
					state_d = cramt_pkg::ST_PASS_END;
				end
			end
			cramt_pkg::ST_U_RD1: state_d = cramt_pkg::ST_U_WR;
			cramt_pkg::ST_U_WR: begin
				state_d = last_u ? cramt_pkg::ST_PASS_END : cramt_pkg::ST_U_SEL;
			end
			cramt_pkg::ST_PASS_END: begin
				if (second_q) begin
					state_d = cramt_pkg::ST_PASS;
				end else if (is_qry) begin
					state_d = cramt_pkg::ST_FINISH;
				end else begin
					state_d = cramt_pkg::ST_IDLE;
				end
			end
			cramt_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = cramt_pkg::ST_IDLE;
				end
			end
			default: state_d = cramt_pkg::ST_IDLE;
		endcase
	end

	// Memory and adder control.
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = v_q;
		ram_raddr = node_w;
		ram_wdata = cw_q;
		alu_in    = ram_rdata;
		alu_add   = p_q;
		cmp_en    = 1'b0;
		cmp_node  = cw_q;
		cmp_key   = clo;
		case (state_q)
			cramt_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '{pend: '0, arg: cramt_pkg::clear_arg(clr_q), mn: '0};
			end
			cramt_pkg::ST_ROOT_RD: begin
				ram_re    = 1'b1;
				ram_raddr = cramt_pkg::NODE_BITS'(1);
			end
			cramt_pkg::ST_ROOT_DO: begin
				alu_add   = value_q;
				ram_we    = is_add;
				ram_waddr = cramt_pkg::NODE_BITS'(1);
				ram_wdata = alu_out;
				cmp_en    = is_qry;
				cmp_node  = ram_rdata;
				cmp_key   = '0;
			end
			cramt_pkg::ST_D_SEL: begin
				ram_re = visit_w;
			end
			cramt_pkg::ST_D_PAR: begin
				ram_we    = (ram_rdata.pend != '0);
				ram_wdata = '{pend: '0, arg: ram_rdata.arg, mn: ram_rdata.mn};
			end
			cramt_pkg::ST_D_CRD: begin
				ram_re    = !cskip;
				ram_raddr = child_w;
			end
			cramt_pkg::ST_D_CAP: begin
				alu_in    = cw_q;
				alu_add   = value_q;
				ram_waddr = child_w;
				if (is_add && ccov) begin
					ram_we    = 1'b1;
					ram_wdata = alu_out;
				end else begin
					ram_we    = (p_q != '0);
				end
				cmp_en = is_qry && ccov;
			end
			cramt_pkg::ST_LEAF: begin
				ram_we    = 1'b1;
				ram_waddr = {1'b1, pl_q};
				ram_wdata = '{pend: '0, arg: pl_q, mn: value_q};
			end
			cramt_pkg::ST_U_SEL: begin
				ram_re    = visit_w;
				ram_raddr = {node_w[cramt_pkg::NODE_BITS-2:0], 1'b0};
			end
			cramt_pkg::ST_U_RD1: begin
				ram_re    = 1'b1;
				ram_raddr = {v_q[cramt_pkg::NODE_BITS-2:0], 1'b1};
			end
			cramt_pkg::ST_U_WR: begin
				ram_we    = 1'b1;
				ram_wdata = '{pend: '0,
				              arg: pick_left ? cw_q.arg : ram_rdata.arg,
				              mn: pick_left ? cw_q.mn : ram_rdata.mn};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cramt_pkg::ST_CLEAR;
			clr_q       <= '0;
			size_q      <= cramt_pkg::SIZE_RESET;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			second_q    <= 1'b0;
			lvl_q       <= '0;
			side_q      <= 1'b0;
			ch_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				size_q <= cfg_wr_data;
			end
			if (state_q == cramt_pkg::ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmp_en && cmp_take) begin
				found_q <= 1'b1;
			end
			case (state_q)
				cramt_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
				cramt_pkg::ST_IDLE: found_q <= 1'b0;
				cramt_pkg::ST_WRAP: begin
					if (div_res.done) begin
						second_q <= !is_load && (div_res.left_pos > div_res.right_pos);
					end
				end
				cramt_pkg::ST_PASS: begin
					lvl_q  <= '0;
					side_q <= 1'b0;
				end
				cramt_pkg::ST_PASS_END: second_q <= 1'b0;
				cramt_pkg::ST_D_PAR: ch_q <= 1'b0;
				cramt_pkg::ST_D_SEL, cramt_pkg::ST_D_CRD, cramt_pkg::ST_D_CAP: begin
					if ((state_q == cramt_pkg::ST_D_SEL && !visit_w)
					    || (state_q != cramt_pkg::ST_D_SEL && ch_q
					        && (state_q == cramt_pkg::ST_D_CAP || cskip))) begin
						if (last_d) begin
							lvl_q  <= cramt_pkg::LEVEL_BITS'(cramt_pkg::LAST_LEVEL);
							side_q <= 1'b0;
						end else if (!side_q && !is_load) begin
							side_q <= 1'b1;
						end else begin
							side_q <= 1'b0;
							lvl_q  <= lvl_q + 1'b1;
						end
					end else if (state_q == cramt_pkg::ST_D_CAP
					             || (state_q == cramt_pkg::ST_D_CRD && cskip)) begin
						ch_q <= 1'b1;
					end
				end
				cramt_pkg::ST_U_SEL, cramt_pkg::ST_U_WR: begin
					if ((state_q == cramt_pkg::ST_U_WR || !visit_w) && !last_u) begin
						if (!side_q && !is_load) begin
							side_q <= 1'b1;
						end else begin
							side_q <= 1'b0;
							lvl_q  <= lvl_q - 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= command;
			value_q <= value;
		end
		if (state_q == cramt_pkg::ST_WRAP && div_res.done) begin
			if (is_load || div_res.left_pos <= div_res.right_pos) begin
				pl_q <= div_res.left_pos;
			end else begin
				pl_q <= '0;
			end
			pr_q <= div_res.right_pos;
			bl_q <= div_res.left_pos;
			br_q <= n_less[cramt_pkg::LEAF_BITS-1:0];
		end
		if (state_q == cramt_pkg::ST_PASS_END && second_q) begin
			pl_q <= bl_q;
			pr_q <= br_q;
		end
		if (state_q == cramt_pkg::ST_D_SEL || state_q == cramt_pkg::ST_U_SEL) begin
			v_q <= node_w;
		end
		if (state_q == cramt_pkg::ST_D_PAR) begin
			p_q <= ram_rdata.pend;
		end
		if (state_q == cramt_pkg::ST_D_CWR) begin
			cw_q <= (p_q != '0) ? alu_out : ram_rdata;
		end
		if (state_q == cramt_pkg::ST_U_RD1) begin
			cw_q <= ram_rdata;
		end
		if (cmp_en && cmp_take) begin
			best_mn_q  <= cmp_node.mn;
			best_arg_q <= cmp_node.arg;
			best_key_q <= cmp_key;
		end
		if (state_q == cramt_pkg::ST_FINISH && out_free) begin
			min_value_q <= best_mn_q;
			min_index_q <= best_arg_q;
		end
	end

	assign out_valid = out_valid_q;
	assign min_value = min_value_q;
	assign min_index = min_index_q;

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == cramt_pkg::ST_FINISH)
		else $error("Result raised outside the finishing step.");

	a_ram_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> ram_waddr != ram_raddr)
		else $error("Node memory read and written at one address in one cycle.");

	a_div_done_in_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == cramt_pkg::ST_WRAP)
		else $error("Bound reduction finished while the sequencer was not waiting.");

endmodule

// File: rtl/core/cramt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module cramt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/cramt_div.sv
`timescale 1ns / 1ps
// Bit-serial reduction of both signed bounds modulo the active size, one bit a cycle.
// Depends on cramt_pkg.
module cramt_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [cramt_pkg::COORD_WIDTH-1:0] left,
	input  logic signed [cramt_pkg::COORD_WIDTH-1:0] right,
	input  logic [cramt_pkg::SIZE_WIDTH-1:0]       modulus,
	output cramt_pkg::div_res_t                    res
);

	logic                                 busy_q;
	logic                                 done_q;
	logic [cramt_pkg::STEP_BITS-1:0]      cnt_q;
	logic [cramt_pkg::SIZE_WIDTH-1:0]     n_q;
	logic [cramt_pkg::COORD_WIDTH-1:0]    mag_q   [2];
	logic [cramt_pkg::LEAF_BITS-1:0]      rem_q   [2];
	logic                                 neg_q   [2];
	logic [cramt_pkg::LEAF_BITS-1:0]      pos_q   [2];
	logic [cramt_pkg::SIZE_WIDTH-1:0]     trial   [2];
	logic [cramt_pkg::SIZE_WIDTH-1:0]     fixed   [2];
	logic [cramt_pkg::COORD_WIDTH-1:0]    num     [2];

	assign num[0] = left;
	assign num[1] = right;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			trial[i] = {rem_q[i], mag_q[i][cramt_pkg::COORD_WIDTH-1]};
			fixed[i] = n_q - {1'b0, rem_q[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == cramt_pkg::STEP_BITS'(cramt_pkg::DIV_STEPS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= modulus;
			for (int i = 0; i < 2; i++) begin
				neg_q[i] <= num[i][cramt_pkg::COORD_WIDTH-1];
				mag_q[i] <= num[i][cramt_pkg::COORD_WIDTH-1] ? (~num[i] + 1'b1) : num[i];
				rem_q[i] <= '0;
			end
		end else if (busy_q) begin
			for (int i = 0; i < 2; i++) begin
				if (cnt_q == cramt_pkg::STEP_BITS'(cramt_pkg::DIV_STEPS)) begin
					pos_q[i] <= (neg_q[i] && rem_q[i] != '0)
						? fixed[i][cramt_pkg::LEAF_BITS-1:0] : rem_q[i];
				end else begin
					mag_q[i] <= mag_q[i] << 1;
					if (trial[i] >= n_q) begin
						rem_q[i] <= cramt_pkg::LEAF_BITS'(trial[i] - n_q);
					end else begin
						rem_q[i] <= trial[i][cramt_pkg::LEAF_BITS-1:0];
					end
				end
			end
		end
	end

	assign res.done      = done_q;
	assign res.left_pos  = pos_q[0];
	assign res.right_pos = pos_q[1];

endmodule
